// ===== hw/rtl/keypad_code_lock_controller_assert.svh =====
// ----------------------------------------------------------------------------
// Keypad code lock assertion macros
// Shared property forms for the lock controller checks.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_CODE_LOCK_CONTROLLER_ASSERT_SVH
`define KEYPAD_CODE_LOCK_CONTROLLER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define KCL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define KCL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/kcl_pkg.sv =====
// ----------------------------------------------------------------------------
// Keypad code lock package
// Widths, key codes, display codes and shared types of the lock controller.
// ----------------------------------------------------------------------------
package kcl_pkg;

    localparam int CODE_DIGITS = 4;

    localparam int KEY_W     = 4;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int COUNT_W   = 8;
    localparam int FAIL_W    = 3;
    localparam int DISP_W    = 3;
    localparam int SHOWN_W   = 3;

    // key codes
    localparam logic [KEY_W-1:0] KEY_EXIT    = 4'd12;
    localparam logic [KEY_W-1:0] KEY_SET     = 4'd13;
    localparam logic [KEY_W-1:0] KEY_ENTER   = 4'd14;
    localparam logic [KEY_W-1:0] KEY_CONFIRM = 4'd15;

    // operation codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_KEY  = 1'b1;

    // display codes
    localparam logic [DISP_W-1:0] DISP_BLANK = 3'd0;
    localparam logic [DISP_W-1:0] DISP_SET   = 3'd1;
    localparam logic [DISP_W-1:0] DISP_ENTRY = 3'd2;
    localparam logic [DISP_W-1:0] DISP_ERR   = 3'd3;
    localparam logic [DISP_W-1:0] DISP_OPEN  = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOGGLE_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOGGLE_TOTAL    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FAILURES    = 2'd2;

    localparam logic [COUNT_W-1:0] TOGGLE_INTERVAL_RST = 8'd39;
    localparam logic [COUNT_W-1:0] TOGGLE_TOTAL_RST    = 8'd60;
    localparam logic [FAIL_W-1:0]  MAX_FAILURES_RST    = 3'd3;
    localparam logic [FAIL_W-1:0]  FAIL_SAT            = 3'd7;

    typedef struct packed {
        logic [COUNT_W-1:0] toggle_interval;
        logic [COUNT_W-1:0] toggle_total;
        logic [FAIL_W-1:0]  max_failures;
    } t_cfg;

    typedef struct packed {
        logic [DISP_W-1:0]  display_mode;
        logic [SHOWN_W-1:0] digits_shown;
        logic               unlocked;
        logic               beeper_level;
        logic               alarm_active;
        logic [FAIL_W-1:0]  failures;
    } t_result;

endpackage

// ===== hw/rtl/kcl_core.sv =====
// ----------------------------------------------------------------------------
// Keypad code lock core
// Lock mode machine, code storage and alarm timing; one request per step.
// ----------------------------------------------------------------------------
module kcl_core #(
    parameter int CODE_DIGITS = kcl_pkg::CODE_DIGITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  logic                         i_operation,
    input  logic [kcl_pkg::KEY_W-1:0]    i_key_code,
    input  kcl_pkg::t_cfg                i_cfg,
    output kcl_pkg::t_result             o_result
);

    localparam int IDX_W = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CODE_DIGITS - 1);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_SET,
        MODE_ENTER,
        MODE_CONFIRM,
        MODE_OPEN,
        MODE_ERR,
        MODE_ALARM
    } t_mode;

    t_mode                           r_mode,         n_mode;
    logic [IDX_W-1:0]                r_digit_index,  n_digit_index;
    logic                            r_code_valid,   n_code_valid;
    logic [kcl_pkg::FAIL_W-1:0]      r_fail_count,   n_fail_count;
    logic [kcl_pkg::COUNT_W-1:0]     r_tick_count,   n_tick_count;
    logic [kcl_pkg::COUNT_W-1:0]     r_toggle_count, n_toggle_count;
    logic                            r_beeper,       n_beeper;
    logic [kcl_pkg::KEY_W-1:0]       r_stored_code  [CODE_DIGITS];
    logic [kcl_pkg::KEY_W-1:0]       r_entered_code [CODE_DIGITS];

    logic                            s_set_wr;
    logic                            s_enter_wr;
    logic                            s_match;
    logic [kcl_pkg::FAIL_W-1:0]      s_fail_inc;
    logic [kcl_pkg::COUNT_W-1:0]     s_tick_inc;
    logic [kcl_pkg::COUNT_W-1:0]     s_toggle_inc;

    always_comb begin
        s_match = r_code_valid;
        for (int d = 0; d < CODE_DIGITS; d++) begin
            if (r_stored_code[d] != r_entered_code[d]) begin
                s_match = 1'b0;
            end
        end
    end

    assign s_fail_inc   = (r_fail_count < kcl_pkg::FAIL_SAT) ?
                          kcl_pkg::FAIL_W'(r_fail_count + 1'b1) : r_fail_count;
    assign s_tick_inc   = kcl_pkg::COUNT_W'(r_tick_count + 1'b1);
    assign s_toggle_inc = kcl_pkg::COUNT_W'(r_toggle_count + 1'b1);

    always_comb begin
        n_mode         = r_mode;
        n_digit_index  = r_digit_index;
        n_code_valid   = r_code_valid;
        n_fail_count   = r_fail_count;
        n_tick_count   = r_tick_count;
        n_toggle_count = r_toggle_count;
        n_beeper       = r_beeper;
        s_set_wr       = 1'b0;
        s_enter_wr     = 1'b0;

        if (i_step) begin
            if (i_operation == kcl_pkg::OP_KEY) begin
                unique case (r_mode)
                    MODE_IDLE: begin
                        if (i_key_code == kcl_pkg::KEY_SET) begin
                            n_mode        = MODE_SET;
                            n_digit_index = '0;
                        end else if (i_key_code == kcl_pkg::KEY_ENTER) begin
                            n_mode        = MODE_ENTER;
                            n_digit_index = '0;
                        end
                    end
                    MODE_SET: begin
                        // control keys count as digits here
                        s_set_wr = 1'b1;
                        if (r_digit_index == LAST_IDX) begin
                            n_code_valid  = 1'b1;
                            n_digit_index = '0;
                            n_mode        = MODE_IDLE;
                        end else begin
                            n_digit_index = IDX_W'(r_digit_index + 1'b1);
                        end
                    end
                    MODE_ENTER: begin
                        s_enter_wr = 1'b1;
                        if (r_digit_index == LAST_IDX) begin
                            n_digit_index = '0;
                            n_mode        = MODE_CONFIRM;
                        end else begin
                            n_digit_index = IDX_W'(r_digit_index + 1'b1);
                        end
                    end
                    MODE_CONFIRM: begin
                        if (i_key_code == kcl_pkg::KEY_CONFIRM) begin
                            if (s_match) begin
                                n_mode = MODE_OPEN;
                            end else begin
                                n_fail_count = s_fail_inc;
                                // a limit of zero trips like a limit of one
                                if (s_fail_inc >= i_cfg.max_failures) begin
                                    n_mode         = MODE_ALARM;
                                    n_tick_count   = '0;
                                    n_toggle_count = '0;
                                end else begin
                                    n_mode = MODE_ERR;
                                end
                            end
                        end
                    end
                    MODE_OPEN: begin
                        if (i_key_code == kcl_pkg::KEY_EXIT) begin
                            n_mode = MODE_IDLE;
                        end
                    end
                    MODE_ERR: begin
                        if (i_key_code == kcl_pkg::KEY_ENTER) begin
                            n_mode = MODE_IDLE;
                        end
                    end
                    MODE_ALARM: begin
                    end
                    default: begin
                        n_mode = MODE_IDLE;
                    end
                endcase
            end else if (r_mode == MODE_ALARM) begin
                n_tick_count = s_tick_inc;
                if (s_tick_inc >= i_cfg.toggle_interval) begin
                    n_tick_count   = '0;
                    n_beeper       = ~r_beeper;
                    n_toggle_count = s_toggle_inc;
                    if (s_toggle_inc >= i_cfg.toggle_total) begin
                        n_fail_count = '0;
                        n_beeper     = 1'b1;
                        n_mode       = MODE_IDLE;
                    end
                end
            end
        end
    end

    // result reflects the state after this request
    always_comb begin
        o_result              = '0;
        o_result.unlocked     = (n_mode == MODE_OPEN);
        o_result.beeper_level = n_beeper;
        o_result.alarm_active = (n_mode == MODE_ALARM);
        o_result.failures     = n_fail_count;
        unique case (n_mode)
            MODE_SET: begin
                o_result.display_mode = kcl_pkg::DISP_SET;
                o_result.digits_shown = kcl_pkg::SHOWN_W'(n_digit_index);
            end
            MODE_ENTER: begin
                o_result.display_mode = kcl_pkg::DISP_ENTRY;
                o_result.digits_shown = kcl_pkg::SHOWN_W'(n_digit_index);
            end
            MODE_CONFIRM: begin
                o_result.display_mode = kcl_pkg::DISP_ENTRY;
                o_result.digits_shown = kcl_pkg::SHOWN_W'(CODE_DIGITS);
            end
            MODE_ERR: begin
                o_result.display_mode = kcl_pkg::DISP_ERR;
            end
            MODE_OPEN: begin
                o_result.display_mode = kcl_pkg::DISP_OPEN;
            end
            default: begin
                o_result.display_mode = kcl_pkg::DISP_BLANK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_IDLE;
            r_digit_index  <= '0;
            r_code_valid   <= 1'b0;
            r_fail_count   <= '0;
            r_tick_count   <= '0;
            r_toggle_count <= '0;
            r_beeper       <= 1'b1;
        end else begin
            r_mode         <= n_mode;
            r_digit_index  <= n_digit_index;
            r_code_valid   <= n_code_valid;
            r_fail_count   <= n_fail_count;
            r_tick_count   <= n_tick_count;
            r_toggle_count <= n_toggle_count;
            r_beeper       <= n_beeper;
        end
        // code digits hold no reset; they are read only after being filled
        if (s_set_wr) begin
            r_stored_code[r_digit_index] <= i_key_code;
        end
        if (s_enter_wr) begin
            r_entered_code[r_digit_index] <= i_key_code;
        end
    end

endmodule

// ===== hw/rtl/keypad_code_lock_controller.sv =====
// Path: each request passes the input register, then the result register, which holds its result.
// Throughput: one request per cycle unless the result side stalls; one lock update per request.
// Input stalls only while both registers hold requests and the result side is stalled.
// Reset (synchronous, active low): lock idle, no valid code, fail count and alarm
// counters cleared, beeper at silent level, config registers at default values.
// ----------------------------------------------------------------------------
// Keypad code lock controller
// Four-digit code lock with failure counting and beeper lockout alarm.
// ----------------------------------------------------------------------------
`include "keypad_code_lock_controller_assert.svh"

module keypad_code_lock_controller #(
    parameter int CODE_DIGITS = kcl_pkg::CODE_DIGITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_operation,
    input  logic [kcl_pkg::KEY_W-1:0]         i_key_code,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [kcl_pkg::DISP_W-1:0]        o_display_mode,
    output logic [kcl_pkg::SHOWN_W-1:0]       o_digits_shown,
    output logic                              o_unlocked,
    output logic                              o_beeper_level,
    output logic                              o_alarm_active,
    output logic [kcl_pkg::FAIL_W-1:0]        o_failures,
    input  logic                              i_cfg_we,
    input  logic [kcl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [kcl_pkg::CFG_W-1:0]         i_cfg_data
);

    kcl_pkg::t_cfg              r_cfg;
    logic                       r_in_valid;
    logic                       r_in_operation;
    logic [kcl_pkg::KEY_W-1:0]  r_in_key_code;
    logic                       r_out_valid;
    kcl_pkg::t_result           r_out;
    kcl_pkg::t_result           s_result;
    logic                       s_out_free;
    logic                       s_step;
    logic                       s_in_accept;

    assign s_out_free  = !r_out_valid || !i_out_stall;
    assign s_step      = r_in_valid && s_out_free;
    assign o_in_stall  = r_in_valid && !s_out_free;
    assign s_in_accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.toggle_interval <= kcl_pkg::TOGGLE_INTERVAL_RST;
            r_cfg.toggle_total    <= kcl_pkg::TOGGLE_TOTAL_RST;
            r_cfg.max_failures    <= kcl_pkg::MAX_FAILURES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                kcl_pkg::CFG_TOGGLE_INTERVAL: r_cfg.toggle_interval <= i_cfg_data;
                kcl_pkg::CFG_TOGGLE_TOTAL:    r_cfg.toggle_total    <= i_cfg_data;
                kcl_pkg::CFG_MAX_FAILURES:
                    r_cfg.max_failures <= i_cfg_data[kcl_pkg::FAIL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_in_accept) begin
                r_in_valid <= 1'b1;
            end else if (s_step) begin
                r_in_valid <= 1'b0;
            end
            if (s_step) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (s_in_accept) begin
            r_in_operation <= i_operation;
            r_in_key_code  <= i_key_code;
        end
        if (s_step) begin
            r_out <= s_result;
        end
    end

    kcl_core #(
        .CODE_DIGITS (CODE_DIGITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (s_step),
        .i_operation (r_in_operation),
        .i_key_code  (r_in_key_code),
        .i_cfg       (r_cfg),
        .o_result    (s_result)
    );

    assign o_out_valid    = r_out_valid;
    assign o_display_mode = r_out.display_mode;
    assign o_digits_shown = r_out.digits_shown;
    assign o_unlocked     = r_out.unlocked;
    assign o_beeper_level = r_out.beeper_level;
    assign o_alarm_active = r_out.alarm_active;
    assign o_failures     = r_out.failures;

    `KCL_ASSERT_NEXT(a_step_gives_result, i_clk, i_rst_n, s_step, r_out_valid, "request processed without a result")
    `KCL_ASSERT_NEXT(a_blocked_req_kept, i_clk, i_rst_n, o_in_stall, r_in_valid && $stable(r_in_key_code), "blocked request lost from input register")
    `KCL_ASSERT_NOW(a_stall_only_when_full, i_clk, i_rst_n, o_in_stall, r_in_valid && r_out_valid && i_out_stall, "input stalled with free room")

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// Keypad code lock controller testbench
// Drives key presses and timer ticks with random idle bursts on both sides.
// A software copy of the lock tracks the code, entry, fail count and alarm
// counters, and each returned panel state is checked against it in order.
// Covers config writes between phases, including changes during an alarm.
// ----------------------------------------------------------------------------
module tb;

    typedef enum logic [2:0] {
        LK_IDLE, LK_SET, LK_ENTER, LK_CONFIRM, LK_OPEN, LK_ERR, LK_ALARM
    } t_lock_state;

    class t_lock_checker;
        logic [kcl_pkg::COUNT_W-1:0] interval   = kcl_pkg::TOGGLE_INTERVAL_RST;
        logic [kcl_pkg::COUNT_W-1:0] total      = kcl_pkg::TOGGLE_TOTAL_RST;
        logic [kcl_pkg::FAIL_W-1:0]  fail_limit = kcl_pkg::MAX_FAILURES_RST;

        t_lock_state                 mode = LK_IDLE;
        int unsigned                 digit_idx = 0;
        logic [kcl_pkg::KEY_W-1:0]   code [kcl_pkg::CODE_DIGITS];
        logic [kcl_pkg::KEY_W-1:0]   entry [kcl_pkg::CODE_DIGITS];
        bit                          code_set = 1'b0;
        logic [kcl_pkg::FAIL_W-1:0]  fails = '0;
        logic [kcl_pkg::COUNT_W-1:0] ticks = '0;
        logic [kcl_pkg::COUNT_W-1:0] toggles = '0;
        bit                          beep = 1'b1;

        kcl_pkg::t_result            panel_q[$];
        int                          mismatches = 0;

        function void set_reg(logic [kcl_pkg::CFG_IDX_W-1:0] idx,
                              logic [kcl_pkg::CFG_W-1:0] val);
            case (idx)
                kcl_pkg::CFG_TOGGLE_INTERVAL: interval = val;
                kcl_pkg::CFG_TOGGLE_TOTAL:    total = val;
                kcl_pkg::CFG_MAX_FAILURES:    fail_limit = val[kcl_pkg::FAIL_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return panel_q.size();
        endfunction

        function bit entry_matches();
            if (!code_set)
                return 1'b0;
            for (int i = 0; i < kcl_pkg::CODE_DIGITS; i++)
                if (code[i] != entry[i])
                    return 1'b0;
            return 1'b1;
        endfunction

        // advance the lock by one accepted request and queue the panel state
        function void note_request(logic op, logic [kcl_pkg::KEY_W-1:0] key);
            kcl_pkg::t_result r;
            if (op == kcl_pkg::OP_TICK) begin
                if (mode == LK_ALARM) begin
                    ticks = ticks + 1'b1;
                    // at-or-above compare: lowered or zero settings end early
                    if (ticks >= interval) begin
                        ticks = '0;
                        beep = ~beep;
                        toggles = toggles + 1'b1;
                        if (toggles >= total) begin
                            fails = '0;
                            beep = 1'b1;
                            mode = LK_IDLE;
                        end
                    end
                end
            end else begin
                case (mode)
                    LK_IDLE: begin
                        if (key == kcl_pkg::KEY_SET) begin
                            mode = LK_SET;
                            digit_idx = 0;
                        end else if (key == kcl_pkg::KEY_ENTER) begin
                            mode = LK_ENTER;
                            digit_idx = 0;
                        end
                    end
                    LK_SET: begin
                        code[digit_idx] = key;
                        digit_idx++;
                        if (digit_idx >= kcl_pkg::CODE_DIGITS) begin
                            code_set = 1'b1;
                            digit_idx = 0;
                            mode = LK_IDLE;
                        end
                    end
                    LK_ENTER: begin
                        entry[digit_idx] = key;
                        digit_idx++;
                        if (digit_idx >= kcl_pkg::CODE_DIGITS) begin
                            digit_idx = 0;
                            mode = LK_CONFIRM;
                        end
                    end
                    LK_CONFIRM: begin
                        if (key == kcl_pkg::KEY_CONFIRM) begin
                            if (entry_matches()) begin
                                mode = LK_OPEN;
                            end else begin
                                if (fails != kcl_pkg::FAIL_SAT)
                                    fails = fails + 1'b1;
                                if (fails >= fail_limit) begin
                                    mode = LK_ALARM;
                                    ticks = '0;
                                    toggles = '0;
                                end else begin
                                    mode = LK_ERR;
                                end
                            end
                        end
                    end
                    LK_OPEN: begin
                        if (key == kcl_pkg::KEY_EXIT)
                            mode = LK_IDLE;
                    end
                    LK_ERR: begin
                        if (key == kcl_pkg::KEY_ENTER)
                            mode = LK_IDLE;
                    end
                    default: ;
                endcase
            end

            r = '0;
            case (mode)
                LK_SET: begin
                    r.display_mode = kcl_pkg::DISP_SET;
                    r.digits_shown = kcl_pkg::SHOWN_W'(digit_idx);
                end
                LK_ENTER: begin
                    r.display_mode = kcl_pkg::DISP_ENTRY;
                    r.digits_shown = kcl_pkg::SHOWN_W'(digit_idx);
                end
                LK_CONFIRM: begin
                    r.display_mode = kcl_pkg::DISP_ENTRY;
                    r.digits_shown = kcl_pkg::SHOWN_W'(kcl_pkg::CODE_DIGITS);
                end
                LK_ERR:  r.display_mode = kcl_pkg::DISP_ERR;
                LK_OPEN: r.display_mode = kcl_pkg::DISP_OPEN;
                default: r.display_mode = kcl_pkg::DISP_BLANK;
            endcase
            r.unlocked     = (mode == LK_OPEN);
            r.beeper_level = beep;
            r.alarm_active = (mode == LK_ALARM);
            r.failures     = fails;
            panel_q.push_back(r);
        endfunction

        function void check_result(kcl_pkg::t_result got);
            kcl_pkg::t_result want;
            bit               bad;
            if (panel_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"unexpected result: disp=%0d shown=%0d unl=%0b",
                              " beep=%0b alarm=%0b fails=%0d"},
                             got.display_mode, got.digits_shown, got.unlocked,
                             got.beeper_level, got.alarm_active, got.failures);
                return;
            end
            want = panel_q.pop_front();
            bad = (got.display_mode !== want.display_mode)
               || (got.digits_shown !== want.digits_shown)
               || (got.unlocked     !== want.unlocked)
               || (got.beeper_level !== want.beeper_level)
               || (got.alarm_active !== want.alarm_active)
               || (got.failures     !== want.failures);
            if (bad) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: exp disp=%0d shown=%0d unl=%0b beep=%0b",
                              " alarm=%0b fails=%0d | got disp=%0d shown=%0d",
                              " unl=%0b beep=%0b alarm=%0b fails=%0d"},
                             want.display_mode, want.digits_shown, want.unlocked,
                             want.beeper_level, want.alarm_active, want.failures,
                             got.display_mode, got.digits_shown, got.unlocked,
                             got.beeper_level, got.alarm_active, got.failures);
            end
        endfunction
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    logic                          i_operation = kcl_pkg::OP_TICK;
    logic [kcl_pkg::KEY_W-1:0]     i_key_code = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic [kcl_pkg::DISP_W-1:0]    o_display_mode;
    logic [kcl_pkg::SHOWN_W-1:0]   o_digits_shown;
    logic                          o_unlocked;
    logic                          o_beeper_level;
    logic                          o_alarm_active;
    logic [kcl_pkg::FAIL_W-1:0]    o_failures;
    logic                          i_cfg_we = 1'b0;
    logic [kcl_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [kcl_pkg::CFG_W-1:0]     i_cfg_data = '0;

    t_lock_checker sb = new();

    bit in_gaps_on    = 1'b0;
    bit out_stalls_on = 1'b0;
    int out_hold      = 0;
    int served        = 0;

    keypad_code_lock_controller dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_key_code     (i_key_code),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_display_mode (o_display_mode),
        .o_digits_shown (o_digits_shown),
        .o_unlocked     (o_unlocked),
        .o_beeper_level (o_beeper_level),
        .o_alarm_active (o_alarm_active),
        .o_failures     (o_failures),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // result side: check what is taken this edge, then pick next stall level
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(kcl_pkg::t_result'({o_display_mode, o_digits_shown,
                                                o_unlocked, o_beeper_level,
                                                o_alarm_active, o_failures}));
        if (out_hold != 0) begin
            out_hold--;
            i_out_stall <= 1'b1;
        end else if (out_stalls_on && $urandom_range(0, 11) == 0) begin
            out_hold = $urandom_range(0, 14);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic send_request(input logic op, input logic [kcl_pkg::KEY_W-1:0] key);
        if (in_gaps_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_key_code  <= key;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        sb.note_request(op, key);
        served++;
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_request(kcl_pkg::OP_TICK, 4'($urandom));
    endtask

    task automatic send_keys(input logic [kcl_pkg::KEY_W-1:0] k0,
                             input logic [kcl_pkg::KEY_W-1:0] k1,
                             input logic [kcl_pkg::KEY_W-1:0] k2,
                             input logic [kcl_pkg::KEY_W-1:0] k3);
        send_request(kcl_pkg::OP_KEY, k0);
        send_request(kcl_pkg::OP_KEY, k1);
        send_request(kcl_pkg::OP_KEY, k2);
        send_request(kcl_pkg::OP_KEY, k3);
    endtask

    // hold off the sender until every queued panel state has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (sb.pending() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [kcl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [kcl_pkg::CFG_W-1:0] val);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic [kcl_pkg::CFG_W-1:0] iv,
                              input logic [kcl_pkg::CFG_W-1:0] tt,
                              input logic [kcl_pkg::CFG_W-1:0] mf);
        write_reg(kcl_pkg::CFG_TOGGLE_INTERVAL, iv);
        write_reg(kcl_pkg::CFG_TOGGLE_TOTAL, tt);
        write_reg(kcl_pkg::CFG_MAX_FAILURES, mf);
    endtask

    // one well-formed or broken key sequence, steered by the tracked lock state
    task automatic play_sequence();
        int                        pick;
        bit                        try_match;
        int                        spoil;
        logic [kcl_pkg::KEY_W-1:0] d;
        pick = $urandom_range(0, 99);
        if (sb.mode == LK_ALARM) begin
            if (pick < 90)
                send_ticks($urandom_range(1, 20));
            else
                send_request(kcl_pkg::OP_KEY, 4'($urandom));
        end else if (sb.mode == LK_OPEN && pick < 60) begin
            send_request(kcl_pkg::OP_KEY, kcl_pkg::KEY_EXIT);
        end else if (sb.mode == LK_ERR && pick < 60) begin
            send_request(kcl_pkg::OP_KEY, kcl_pkg::KEY_ENTER);
        end else if (pick < 12) begin
            send_request(kcl_pkg::OP_KEY, kcl_pkg::KEY_SET);
            for (int i = 0; i < kcl_pkg::CODE_DIGITS; i++)
                send_request(kcl_pkg::OP_KEY, 4'($urandom));
        end else if (pick < 62) begin
            try_match = sb.code_set && $urandom_range(0, 1);
            spoil = ($urandom_range(0, 3) == 0) ?
                    $urandom_range(0, kcl_pkg::CODE_DIGITS - 1) : -1;
            send_request(kcl_pkg::OP_KEY, kcl_pkg::KEY_ENTER);
            for (int i = 0; i < kcl_pkg::CODE_DIGITS; i++) begin
                d = (try_match && i != spoil) ? sb.code[i] : 4'($urandom);
                send_request(kcl_pkg::OP_KEY, d);
            end
            if ($urandom_range(0, 4) == 0)
                send_request(kcl_pkg::OP_KEY, 4'($urandom_range(0, 14)));
            if ($urandom_range(0, 9) != 0)
                send_request(kcl_pkg::OP_KEY, kcl_pkg::KEY_CONFIRM);
        end else if (pick < 72) begin
            send_request(kcl_pkg::OP_KEY, kcl_pkg::KEY_EXIT);
        end else if (pick < 80) begin
            send_request(kcl_pkg::OP_KEY, kcl_pkg::KEY_ENTER);
        end else if (pick < 88) begin
            send_ticks($urandom_range(1, 5));
        end else begin
            send_request(logic'($urandom_range(0, 1)), 4'($urandom));
        end
    endtask

    initial begin
        int iv;
        int tt;
        int mf;
        int phase_end;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // stray requests in idle are ignored
        send_request(kcl_pkg::OP_TICK, 4'hF);
        send_request(kcl_pkg::OP_KEY, kcl_pkg::KEY_CONFIRM);
        send_request(kcl_pkg::OP_KEY, 4'd0);
        // no code set yet, so any entry is wrong; control keys count as digits
        send_request(kcl_pkg::OP_KEY, kcl_pkg::KEY_ENTER);
        send_keys(kcl_pkg::KEY_CONFIRM, 4'd0, kcl_pkg::KEY_EXIT, kcl_pkg::KEY_SET);
        send_request(kcl_pkg::OP_KEY, kcl_pkg::KEY_CONFIRM);
        send_request(kcl_pkg::OP_KEY, 4'd5);
        send_request(kcl_pkg::OP_KEY, kcl_pkg::KEY_ENTER);

        set_config(8'd1, 8'd2, 8'd2);
        send_request(kcl_pkg::OP_KEY, kcl_pkg::KEY_SET);
        send_keys(kcl_pkg::KEY_CONFIRM, 4'd0, kcl_pkg::KEY_EXIT, kcl_pkg::KEY_SET);
        send_request(kcl_pkg::OP_KEY, kcl_pkg::KEY_ENTER);
        send_keys(kcl_pkg::KEY_CONFIRM, 4'd0, kcl_pkg::KEY_EXIT, kcl_pkg::KEY_SET);
        send_request(kcl_pkg::OP_KEY, 4'd7);
        send_request(kcl_pkg::OP_KEY, kcl_pkg::KEY_CONFIRM);
        send_request(kcl_pkg::OP_KEY, kcl_pkg::KEY_SET);
        send_request(kcl_pkg::OP_TICK, 4'd0);
        send_request(kcl_pkg::OP_KEY, kcl_pkg::KEY_EXIT);
        // second failure reaches the limit; keys are dead during the alarm
        send_request(kcl_pkg::OP_KEY, kcl_pkg::KEY_ENTER);
        send_keys(4'd1, 4'd2, 4'd3, 4'd4);
        send_request(kcl_pkg::OP_KEY, kcl_pkg::KEY_CONFIRM);
        send_request(kcl_pkg::OP_KEY, kcl_pkg::KEY_ENTER);
        send_ticks(2);

        // zero settings behave as one
        set_config(8'd0, 8'd0, 8'd0);
        send_request(kcl_pkg::OP_KEY, kcl_pkg::KEY_ENTER);
        send_keys(4'd9, 4'd9, 4'd9, 4'd9);
        send_request(kcl_pkg::OP_KEY, kcl_pkg::KEY_CONFIRM);
        send_ticks(1);

        // widest settings, then cut them short in the middle of the alarm
        set_config(8'd255, 8'd255, 8'd1);
        send_request(kcl_pkg::OP_KEY, kcl_pkg::KEY_ENTER);
        send_keys(4'd8, 4'd8, 4'd8, 4'd8);
        send_request(kcl_pkg::OP_KEY, kcl_pkg::KEY_CONFIRM);
        send_ticks(300);
        write_reg(kcl_pkg::CFG_TOGGLE_INTERVAL, 8'd1);
        write_reg(kcl_pkg::CFG_TOGGLE_TOTAL, 8'd1);
        send_ticks(2);
        set_config(8'd2, 8'd3, 8'd7);

        while (served < 1600) begin
            if (served > 1350) begin
                in_gaps_on = 1'b0;
                out_stalls_on = 1'b0;
            end else begin
                in_gaps_on = ($urandom_range(0, 3) != 0);
                out_stalls_on = ($urandom_range(0, 3) != 0);
            end
            iv = ($urandom_range(0, 19) == 0) ? 255 : $urandom_range(1, 4);
            if (iv == 255)
                tt = $urandom_range(1, 2);
            else if (iv == 1 && $urandom_range(0, 9) == 0)
                tt = 255;
            else
                tt = $urandom_range(1, 6);
            mf = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 7) : $urandom_range(1, 3);
            set_config(kcl_pkg::CFG_W'(iv), kcl_pkg::CFG_W'(tt), kcl_pkg::CFG_W'(mf));
            phase_end = served + 150;
            while (served < phase_end && served < 1600)
                play_sequence();
        end

        drain_results();
        repeat (6) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #4000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
